>>> src/roh_pkg.sv
package roh_pkg;

  localparam int DEF_IMG_WIDTH   = 512;
  localparam int DEF_IMG_HEIGHT  = 256;
  localparam int DEF_ORBIT_LIMIT = 65535;

  localparam int NUM_REGS = 8;
  localparam logic [3:0] REG_COS_XZ = 4'd0;
  localparam logic [3:0] REG_SIN_XZ = 4'd1;
  localparam logic [3:0] REG_COS_YW = 4'd2;
  localparam logic [3:0] REG_SIN_YW = 4'd3;
  localparam logic [3:0] REG_COS_XW = 4'd4;
  localparam logic [3:0] REG_SIN_XW = 4'd5;
  localparam logic [3:0] REG_COS_YZ = 4'd6;
  localparam logic [3:0] REG_SIN_YZ = 4'd7;

  localparam logic OP_ACC  = 1'b0;
  localparam logic OP_READ = 1'b1;

  localparam logic signed [31:0] ONE_Q30   = 32'sh4000_0000;
  localparam logic signed [63:0] FOUR_Q28  = 64'sh0000_0000_4000_0000;
  localparam logic signed [63:0] FIVE_Q28  = 64'sh0000_0000_5000_0000;
  localparam logic signed [33:0] STAGE_MAX = 34'sh1_FFFF_FFFF;

  typedef logic signed [33:0] stage_t;
  typedef logic signed [65:0] prod_t;

  function automatic logic signed [31:0] clamp_q30(input logic signed [31:0] v);
    logic signed [31:0] r;
    r = v;
    if (v > ONE_Q30) r = ONE_Q30;
    else if (v < -ONE_Q30) r = -ONE_Q30;
    return r;
  endfunction

  function automatic stage_t sat_stage(input logic signed [67:0] v);
    stage_t r;
    r = v[33:0];
    if (v > 68'(STAGE_MAX)) r = STAGE_MAX;
    else if (v < -68'(STAGE_MAX)) r = -STAGE_MAX;
    return r;
  endfunction

  function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [16:0] b);
    logic [32:0] s;
    s = {1'b0, a} + 33'(b);
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

endpackage

>>> src/rotated_orbit_histogram.sv
// Orbit histogram with 4D rotation. Bins live in one single-port memory of
// IMG_WIDTH*IMG_HEIGHT words (red, green, blue side by side). After reset a
// clearing pass writes every word, one per cycle; busy stays high meanwhile.
// An accumulate item runs the ratio divider (skipped when step_index is not
// below orbit_length), then for each of the direct and mirrored points the
// rotation, projection, read and write-back of the bin (no write-back when
// the point misses the image). A read item returns the bin and clears it.
// done pulses for one cycle with the result and cannot be held off;
// configuration is always accepted.
module rotated_orbit_histogram #(
  parameter int IMG_WIDTH   = roh_pkg::DEF_IMG_WIDTH,
  parameter int IMG_HEIGHT  = roh_pkg::DEF_IMG_HEIGHT,
  parameter int ORBIT_LIMIT = roh_pkg::DEF_ORBIT_LIMIT
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic               operation,
  input  logic signed [31:0] point_first,
  input  logic signed [31:0] point_second,
  input  logic signed [31:0] origin_re,
  input  logic signed [31:0] origin_im,
  input  logic [15:0]        step_index,
  input  logic [15:0]        orbit_length,
  input  logic [8:0]         read_column,
  input  logic [7:0]         read_row,
  output logic               done,
  output logic [31:0]        red_sum,
  output logic [31:0]        green_sum,
  output logic [31:0]        blue_count,
  output logic               direct_hit,
  output logic               mirror_hit,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [3:0]         cfg_index,
  input  logic [31:0]        cfg_data
);
  import roh_pkg::*;

  localparam int DEPTH = IMG_WIDTH * IMG_HEIGHT;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = $clog2(IMG_WIDTH);
  localparam int RW    = $clog2(IMG_HEIGHT);
  localparam logic signed [63:0] OFF_TERM = 64'((IMG_WIDTH - IMG_HEIGHT) / 2) <<< 31;

  localparam logic [3:0] S_CLR  = 4'd0;
  localparam logic [3:0] S_IDLE = 4'd1;
  localparam logic [3:0] S_DIV  = 4'd2;
  localparam logic [3:0] S_M1   = 4'd3;
  localparam logic [3:0] S_S1   = 4'd4;
  localparam logic [3:0] S_M2   = 4'd5;
  localparam logic [3:0] S_S2   = 4'd6;
  localparam logic [3:0] S_PRJ  = 4'd7;
  localparam logic [3:0] S_POS  = 4'd8;
  localparam logic [3:0] S_ADR  = 4'd9;
  localparam logic [3:0] S_RD   = 4'd10;
  localparam logic [3:0] S_WR   = 4'd11;
  localparam logic [3:0] S_RA   = 4'd12;
  localparam logic [3:0] S_RRD  = 4'd13;
  localparam logic [3:0] S_RWR  = 4'd14;

  logic [3:0] state;
  logic signed [31:0] cfg_q [NUM_REGS];

  logic               pass;
  logic signed [31:0] p1, p2, ore, oim;
  logic [15:0]        lenv;
  logic [8:0]         rcol;
  logic [7:0]         rrow;
  logic [16:0]        rem;
  logic [15:0]        quo;
  logic [4:0]         dcnt;
  logic [16:0]        rinc;
  logic [16:0]        ginc;
  prod_t              m [8];
  stage_t             cx, cz, cy, cw, fx, fy;
  logic signed [63:0] tc, tr;
  logic signed [63:0] colv, rowv;
  logic               inb;
  logic               hit0;
  logic [AW-1:0]      addr;
  logic [AW-1:0]      clr_addr;

  logic [95:0]        mem [DEPTH];
  logic [95:0]        rdata;
  logic [AW-1:0]      mem_addr;
  logic               mem_we;
  logic [95:0]        mem_wdata;

  stage_t             vx, vy, vz, vw;
  logic [15:0]        lenc;
  logic [16:0]        r2;

  assign busy      = (state != S_IDLE);
  assign cfg_ready = 1'b1;
  assign ginc      = 17'h10000 - rinc;

  assign vx = pass ? -34'(p1) : 34'(p1);
  assign vy = 34'(p2);
  assign vz = 34'(ore);
  assign vw = pass ? -34'(oim) : 34'(oim);
  assign lenc = (32'(orbit_length) > ORBIT_LIMIT) ? 16'(ORBIT_LIMIT) : orbit_length;
  assign r2 = {rem[15:0], 1'b0};

  always_comb begin
    mem_addr  = (state == S_CLR) ? clr_addr : addr;
    mem_we    = (state == S_CLR) || (state == S_WR) || (state == S_RWR && inb);
    mem_wdata = '0;
    if (state == S_WR) begin
      mem_wdata = {sat_add(rdata[95:64], rinc), sat_add(rdata[63:32], ginc),
                   sat_add(rdata[31:0], 17'd1)};
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_addr] <= mem_wdata;
    rdata <= mem[mem_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_q[REG_COS_XZ[2:0]] <= ONE_Q30;
      cfg_q[REG_SIN_XZ[2:0]] <= '0;
      cfg_q[REG_COS_YW[2:0]] <= ONE_Q30;
      cfg_q[REG_SIN_YW[2:0]] <= '0;
      cfg_q[REG_COS_XW[2:0]] <= ONE_Q30;
      cfg_q[REG_SIN_XW[2:0]] <= '0;
      cfg_q[REG_COS_YZ[2:0]] <= ONE_Q30;
      cfg_q[REG_SIN_YZ[2:0]] <= '0;
    end else if (cfg_valid && cfg_index < 4'(NUM_REGS)) begin
      cfg_q[cfg_index[2:0]] <= clamp_q30(cfg_data);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLR;
      clr_addr <= '0;
      done     <= 1'b0;
      pass     <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_CLR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == AW'(DEPTH - 1)) state <= S_IDLE;
        end
        S_IDLE: begin
          if (start) begin
            p1 <= point_first; p2 <= point_second;
            ore <= origin_re;  oim <= origin_im;
            lenv <= lenc;
            rcol <= read_column; rrow <= read_row;
            pass <= 1'b0;
            hit0 <= 1'b0;
            if (operation == OP_READ) begin
              state <= S_RA;
            end else if (step_index >= lenc) begin
              rinc  <= 17'h10000;
              state <= S_M1;
            end else begin
              rem   <= 17'(step_index);
              quo   <= '0;
              dcnt  <= 5'd16;
              state <= S_DIV;
            end
          end
        end
        S_DIV: begin
          if (r2 >= 17'(lenv)) begin
            rem <= r2 - 17'(lenv);
            quo <= {quo[14:0], 1'b1};
          end else begin
            rem <= r2;
            quo <= {quo[14:0], 1'b0};
          end
          dcnt <= dcnt - 1'b1;
          if (dcnt == 5'd1) begin
            rinc  <= {1'b0, quo[14:0], (r2 >= 17'(lenv))};
            state <= S_M1;
          end
        end
        S_M1: begin
          m[0] <= vx * cfg_q[REG_COS_XZ[2:0]];
          m[1] <= vz * cfg_q[REG_SIN_XZ[2:0]];
          m[2] <= vx * cfg_q[REG_SIN_XZ[2:0]];
          m[3] <= vz * cfg_q[REG_COS_XZ[2:0]];
          m[4] <= vy * cfg_q[REG_COS_YW[2:0]];
          m[5] <= vw * cfg_q[REG_SIN_YW[2:0]];
          m[6] <= vy * cfg_q[REG_SIN_YW[2:0]];
          m[7] <= vw * cfg_q[REG_COS_YW[2:0]];
          state <= S_S1;
        end
        S_S1: begin
          cx <= sat_stage(68'(m[0] >>> 30) - 68'(m[1] >>> 30));
          cz <= sat_stage(68'(m[2] >>> 30) + 68'(m[3] >>> 30));
          cy <= sat_stage(68'(m[4] >>> 30) - 68'(m[5] >>> 30));
          cw <= sat_stage(68'(m[6] >>> 30) + 68'(m[7] >>> 30));
          state <= S_M2;
        end
        S_M2: begin
          m[0] <= cx * cfg_q[REG_COS_XW[2:0]];
          m[1] <= cw * cfg_q[REG_SIN_XW[2:0]];
          m[2] <= cy * cfg_q[REG_COS_YZ[2:0]];
          m[3] <= cz * cfg_q[REG_SIN_YZ[2:0]];
          state <= S_S2;
        end
        S_S2: begin
          fx <= sat_stage(68'(m[0] >>> 30) - 68'(m[1] >>> 30));
          fy <= sat_stage(68'(m[2] >>> 30) - 68'(m[3] >>> 30));
          state <= S_PRJ;
        end
        S_PRJ: begin
          tc <= OFF_TERM + (3 * 64'(fy) + FIVE_Q28) * 64'(IMG_HEIGHT);
          tr <= (3 * 64'(fx) + FOUR_Q28) * 64'(IMG_HEIGHT);
          state <= S_POS;
        end
        S_POS: begin
          // truncate toward zero
          colv  <= tc[63] ? -((-tc) >>> 31) : (tc >>> 31);
          rowv  <= tr[63] ? -((-tr) >>> 31) : (tr >>> 31);
          state <= S_ADR;
        end
        S_ADR: begin
          inb <= !colv[63] && !rowv[63] && colv < 64'(IMG_WIDTH) && rowv < 64'(IMG_HEIGHT);
          addr <= AW'(32'(rowv[RW-1:0]) * IMG_WIDTH + 32'(colv[CW-1:0]));
          state <= S_RD;
        end
        S_RD: begin
          state <= inb ? S_WR : S_M1;
          if (!inb) begin
            pass <= 1'b1;
            if (pass) begin
              state      <= S_IDLE;
              done       <= 1'b1;
              direct_hit <= hit0;
              mirror_hit <= 1'b0;
              red_sum    <= '0;
              green_sum  <= '0;
              blue_count <= '0;
            end
          end
        end
        S_WR: begin
          pass <= 1'b1;
          if (!pass) begin
            hit0  <= 1'b1;
            state <= S_M1;
          end else begin
            state      <= S_IDLE;
            done       <= 1'b1;
            direct_hit <= hit0;
            mirror_hit <= 1'b1;
            red_sum    <= '0;
            green_sum  <= '0;
            blue_count <= '0;
          end
        end
        S_RA: begin
          inb  <= 32'(rcol) < IMG_WIDTH && 32'(rrow) < IMG_HEIGHT;
          addr <= AW'(32'(rrow) * IMG_WIDTH + 32'(rcol));
          state <= S_RRD;
        end
        S_RRD: begin
          state <= S_RWR;
        end
        S_RWR: begin
          state      <= S_IDLE;
          done       <= 1'b1;
          direct_hit <= 1'b0;
          mirror_hit <= 1'b0;
          red_sum    <= inb ? rdata[95:64] : '0;
          green_sum  <= inb ? rdata[63:32] : '0;
          blue_count <= inb ? rdata[31:0] : '0;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTH
  a_done_from_work: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state) != S_IDLE) else $error("result without work");
  a_hits_no_sums: assert property (@(posedge clk) disable iff (rst)
    (done && (direct_hit || mirror_hit)) |-> (blue_count == 32'd0))
    else $error("accumulate returned bin data");
  a_wr_after_rd: assert property (@(posedge clk) disable iff (rst)
    (state == S_WR) |-> $past(state) == S_RD) else $error("write-back without read");
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy) else $error("accepted item not worked");
`endif

endmodule

>>> bench/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import roh_pkg::*;

  localparam int  CYCLE_LIMIT = 1000000;
  localparam int  TAIL        = 40;
  localparam int  PHASE_ITEMS = 135;
  localparam int  Q28_SPAN    = 348966092;
  localparam longint STAGE_LIM = 64'sd8589934591;

  typedef struct {
    logic        op;
    logic [31:0] pf, ps, ore, oim;
    logic [15:0] j, len;
    logic [8:0]  col;
    logic [7:0]  row;
  } item_t;

  typedef struct {
    logic [31:0] red, green, blue;
    logic        dhit, mhit;
  } bin_result_t;

  class bin_scoreboard;
    longint      coef[NUM_REGS];
    logic [31:0] red_bins[int], green_bins[int], blue_bins[int];
    bin_result_t pending_results[$];
    int          hit_bins[$];
    int          errors, accums, reads, hits;

    function new();
      for (int k = 0; k < NUM_REGS; k++) coef[k] = (k % 2) ? 0 : longint'(ONE_Q30);
    endfunction

    task report(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch %s: got %h want %h", what, got, want);
      errors++;
    endtask

    function void set_reg(logic [3:0] idx, logic [31:0] data);
      longint v;
      v = longint'($signed(data));
      if (idx >= NUM_REGS) return;
      if (v > longint'(ONE_Q30)) v = ONE_Q30;
      if (v < -longint'(ONE_Q30)) v = -longint'(ONE_Q30);
      coef[idx] = v;
    endfunction

    function longint stage(longint v);
      if (v > STAGE_LIM) return STAGE_LIM;
      if (v < -STAGE_LIM) return -STAGE_LIM;
      return v;
    endfunction

    function longint rot_diff(longint a, longint b, longint c, longint s);
      return stage(((a * c) >>> 30) - ((b * s) >>> 30));
    endfunction

    function longint rot_sum(longint a, longint b, longint c, longint s);
      return stage(((a * s) >>> 30) + ((b * c) >>> 30));
    endfunction

    function longint tdiv(longint v);
      return (v >= 0) ? (v >>> 31) : -((-v) >>> 31);
    endfunction

    function bit screen_bin(longint x, longint y, longint z, longint w, output int idx);
      longint cx, cz, cy, cw, fx, fy, c, r;
      cx = rot_diff(x, z, coef[REG_COS_XZ], coef[REG_SIN_XZ]);
      cz = rot_sum(x, z, coef[REG_COS_XZ], coef[REG_SIN_XZ]);
      cy = rot_diff(y, w, coef[REG_COS_YW], coef[REG_SIN_YW]);
      cw = rot_sum(y, w, coef[REG_COS_YW], coef[REG_SIN_YW]);
      fx = rot_diff(cx, cw, coef[REG_COS_XW], coef[REG_SIN_XW]);
      fy = rot_diff(cy, cz, coef[REG_COS_YZ], coef[REG_SIN_YZ]);
      c = tdiv(longint'((DEF_IMG_WIDTH - DEF_IMG_HEIGHT) / 2) * (64'sd1 << 31)
               + (3 * fy + 5 * (64'sd1 << 28)) * DEF_IMG_HEIGHT);
      r = tdiv((3 * fx + 4 * (64'sd1 << 28)) * DEF_IMG_HEIGHT);
      idx = 0;
      if (c < 0 || r < 0 || c >= DEF_IMG_WIDTH || r >= DEF_IMG_HEIGHT) return 0;
      idx = int'(r) * DEF_IMG_WIDTH + int'(c);
      return 1;
    endfunction

    function logic [31:0] sadd(logic [31:0] a, logic [31:0] b);
      logic [32:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[32] ? 32'hFFFF_FFFF : s[31:0];
    endfunction

    function void deposit(int idx, logic [31:0] ri, logic [31:0] gi);
      if (!red_bins.exists(idx)) begin
        red_bins[idx] = '0; green_bins[idx] = '0; blue_bins[idx] = '0;
      end
      red_bins[idx]   = sadd(red_bins[idx], ri);
      green_bins[idx] = sadd(green_bins[idx], gi);
      blue_bins[idx]  = sadd(blue_bins[idx], 32'd1);
      if (hit_bins.size() < 4000) hit_bins.insert(hit_bins.size(), idx);
      hits++;
    endfunction

    function void note_item(item_t it);
      bin_result_t e;
      int idx;
      logic [31:0] ri;
      longint p1, p2, oz, ow;
      e = '{32'd0, 32'd0, 32'd0, 1'b0, 1'b0};
      if (it.op == OP_READ) begin
        reads++;
        idx = int'(it.row) * DEF_IMG_WIDTH + int'(it.col);
        if (red_bins.exists(idx)) begin
          e.red = red_bins[idx]; e.green = green_bins[idx]; e.blue = blue_bins[idx];
          red_bins.delete(idx); green_bins.delete(idx); blue_bins.delete(idx);
        end
      end else begin
        accums++;
        if (it.j >= it.len) ri = 32'd65536;
        else ri = 32'(({16'd0, it.j} << 16) / it.len);
        p1 = longint'($signed(it.pf));  p2 = longint'($signed(it.ps));
        oz = longint'($signed(it.ore)); ow = longint'($signed(it.oim));
        if (screen_bin(p1, p2, oz, ow, idx)) begin
          deposit(idx, ri, 32'd65536 - ri); e.dhit = 1;
        end
        if (screen_bin(-p1, p2, oz, -ow, idx)) begin
          deposit(idx, ri, 32'd65536 - ri); e.mhit = 1;
        end
      end
      pending_results.insert(pending_results.size(), e);
    endfunction

    task check_result(bin_result_t got);
      bin_result_t w;
      if (pending_results.size() == 0) begin
        $display("unexpected result %h %h %h %b%b", got.red, got.green, got.blue,
                 got.dhit, got.mhit);
        errors++;
        return;
      end
      w = pending_results.pop_front();
      if (got.red !== w.red) report("red_sum", got.red, w.red);
      if (got.green !== w.green) report("green_sum", got.green, w.green);
      if (got.blue !== w.blue) report("blue_count", got.blue, w.blue);
      if (got.dhit !== w.dhit) report("direct_hit", 32'(got.dhit), 32'(w.dhit));
      if (got.mhit !== w.mhit) report("mirror_hit", 32'(got.mhit), 32'(w.mhit));
    endtask
  endclass

  logic clk = 0, rst = 1, start = 0, operation = 0;
  logic signed [31:0] point_first = 0, point_second = 0, origin_re = 0, origin_im = 0;
  logic [15:0] step_index = 0, orbit_length = 1;
  logic [8:0]  read_column = 0;
  logic [7:0]  read_row = 0;
  logic        cfg_valid = 0;
  logic [3:0]  cfg_index = 0;
  logic [31:0] cfg_data = 0;
  logic        busy, done, direct_hit, mirror_hit, cfg_ready;
  logic [31:0] red_sum, green_sum, blue_count;
  int          cycles = 0;

  bin_scoreboard sb = new();

  rotated_orbit_histogram dut (.*);

  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("testbench: errors");
      $finish;
    end
  end

  always @(posedge clk)
    if (!rst && done)
      sb.check_result('{red_sum, green_sum, blue_count, direct_hit, mirror_hit});

  function automatic int span(int lo, int hi);
    return lo + int'($urandom_range(0, 32'(hi - lo)));
  endfunction

  task automatic issue(item_t it);
    start <= 1;
    operation <= it.op;
    point_first <= it.pf; point_second <= it.ps;
    origin_re <= it.ore; origin_im <= it.oim;
    step_index <= it.j; orbit_length <= it.len;
    read_column <= it.col; read_row <= it.row;
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.note_item(it);
  endtask

  task automatic pause(int n);
    start <= 0;
    repeat (n) @(posedge clk);
  endtask

  task automatic settle();
    start <= 0;
    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (TAIL) @(posedge clk);
  endtask

  task automatic write_reg(logic [3:0] idx, logic [31:0] data);
    cfg_valid <= 1; cfg_index <= idx; cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.set_reg(idx, data);
    cfg_valid <= 0;
    @(posedge clk);
  endtask

  task automatic write_all(logic [31:0] c, logic [31:0] s);
    write_reg(REG_COS_XZ, c); write_reg(REG_SIN_XZ, s);
    write_reg(REG_COS_YW, c); write_reg(REG_SIN_YW, s);
    write_reg(REG_COS_XW, c); write_reg(REG_SIN_XW, s);
    write_reg(REG_COS_YZ, c); write_reg(REG_SIN_YZ, s);
  endtask

  function automatic item_t acc(int pf, int ps, int ore, int oim, int j, int len);
    return '{OP_ACC, pf, ps, ore, oim, 16'(j), 16'(len), 9'($urandom), 8'($urandom)};
  endfunction

  function automatic item_t rd(int idx);
    item_t it;
    it = '{OP_READ, $urandom, $urandom, $urandom, $urandom, 16'($urandom),
           16'($urandom), 9'd0, 8'd0};
    it.col = 9'(idx % DEF_IMG_WIDTH);
    it.row = 8'(idx / DEF_IMG_WIDTH);
    return it;
  endfunction

  function automatic item_t rand_item();
    int sel, len;
    sel = span(0, 99);
    if (sel < 25) begin
      if (sb.hit_bins.size() != 0 && sel < 20)
        return rd(sb.hit_bins[$urandom_range(0, sb.hit_bins.size() - 1)]);
      return rd(span(0, DEF_IMG_WIDTH * DEF_IMG_HEIGHT - 1));
    end
    if (sel < 35)
      return acc($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
    len = (sel < 90) ? span(1, 120) : span(0, 65535);
    return acc(span(-Q28_SPAN, Q28_SPAN), span(-2 * Q28_SPAN, Q28_SPAN),
               span(-268435456, 268435456), span(-268435456, 268435456),
               span(0, len + 2), len);
  endfunction

  task automatic random_phase(int n);
    int left, burst;
    left = n;
    while (left > 0) begin
      burst = span(1, 20);
      while (burst > 0 && left > 0) begin
        issue(rand_item());
        burst--; left--;
      end
      if (left == n / 2) settle();
      else if (span(0, 3) != 0) pause(span(1, 15));
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed: field extremes, ratio corners, shared bin, reads
    issue(acc(0, 0, 0, 0, 0, 1));
    issue(acc(0, 0, 0, 0, 1, 1));
    issue(acc(0, 0, 0, 0, 5, 0));
    issue(acc(0, 0, 0, 0, 65535, 65535));
    issue(acc(0, 0, 0, 0, 1, 65535));
    issue(acc(0, 0, 0, 0, 65534, 65535));
    issue(acc(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 3, 7));
    issue(acc(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 3, 7));
    issue(acc(32'h1000_0000, 32'hF000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 2, 9));
    issue(acc(32'h1400_0000, 32'h0800_0000, 0, 32'h0200_0000, 4, 10));
    issue(acc(-357913941, -805306368, 0, 0, 0, 3));
    issue(acc(357913941, 715827882, 0, 0, 1, 3));
    pause(3);
    issue(rd(128 * DEF_IMG_WIDTH + 288));
    issue(rd(128 * DEF_IMG_WIDTH + 288));
    issue(rd(0));
    issue(rd(DEF_IMG_WIDTH * DEF_IMG_HEIGHT - 1));
    while (sb.hit_bins.size() != 0) issue(rd(sb.hit_bins.pop_front()));
    settle();

    random_phase(PHASE_ITEMS);
    settle();
    write_all(32'hC000_0000, 32'h0000_0000);
    random_phase(PHASE_ITEMS);
    settle();
    write_all(32'h0000_0000, 32'h4000_0000);
    random_phase(PHASE_ITEMS);
    settle();
    write_all(32'h0000_0000, 32'hC000_0000);
    random_phase(PHASE_ITEMS);
    settle();
    write_all(32'h7FFF_FFFF, 32'h8000_0000);
    for (int k = NUM_REGS; k < 16; k++) write_reg(4'(k), $urandom);
    random_phase(PHASE_ITEMS);
    settle();
    for (int k = 0; k < NUM_REGS; k++) write_reg(4'(k), span(-1073741824, 1073741824));
    random_phase(PHASE_ITEMS);
    settle();
    for (int k = 0; k < 16; k++) write_reg(4'(k), $urandom);
    random_phase(PHASE_ITEMS);
    settle();

    if (sb.pending_results.size() != 0) begin
      $display("%0d results never arrived", sb.pending_results.size());
      sb.errors++;
    end
    $display("covered %0d accumulates and %0d bin reads over seven rotation settings",
             sb.accums, sb.reads);
    $display("%0d bin deposits predicted, %0d mismatches", sb.hits, sb.errors);
    if (sb.errors == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule
